// ===== sv/rc4_pkg.sv =====
// shared types and constants of the rc4 stream cipher
`default_nettype none

package rc4_pkg;

    localparam int KEY_MAX_BYTES_DEF = 256;
    localparam int LEN_W             = 9;
    localparam int BYTE_W            = 8;
    localparam logic [LEN_W-1:0] KEY_LENGTH_RST = 9'd32;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = 1;
    localparam int Q_CW    = 2;

    typedef enum logic [1:0] {
        OP_KEY,
        OP_DATA,
        OP_REKEY
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [BYTE_W-1:0] idx;
        logic [BYTE_W-1:0] value;
    } t_cmd;

endpackage

`default_nettype wire

// ===== sv/rc4_stream_cipher_top.sv =====
// top level of the rc4 stream cipher
//
//  channel   direction  handshake                 payload
//  in        input      i_in_valid / o_in_ready   i_mode i_key_index i_value i_message_start
//  out       output     o_out_valid / i_out_ready o_out_byte
//  cfg       input      i_cfg_we                  i_cfg_wdata (key length)
//
// key request: written to the key store when popped; data request: read i, read j, two swap writes
// message start adds a key schedule (a clear, then 256 rounds of read, read, two swap writes), one swap write per cycle
// on the single write port of the permutation memory
// synchronous active-low reset; permutation restarts as identity through valid bits
// intake register and a two-entry queue keep taking requests while the core or out stalls, until both are full
`default_nettype none

module rc4_stream_cipher_top #(
    parameter int KEY_MAX_BYTES = rc4_pkg::KEY_MAX_BYTES_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [rc4_pkg::LEN_W-1:0]  i_cfg_wdata,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic                       i_mode,
    input  wire logic [7:0]                 i_key_index,
    input  wire logic [7:0]                 i_value,
    input  wire logic                       i_message_start,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic [7:0]                      o_out_byte
);

    logic          push_valid;
    logic          push_ready;
    rc4_pkg::t_cmd push_cmd;
    logic          pop_valid;
    logic          pop_ready;
    rc4_pkg::t_cmd pop_cmd;

    rc4_front #(
        .KEY_MAX_BYTES (KEY_MAX_BYTES)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_mode          (i_mode),
        .i_key_index     (i_key_index),
        .i_value         (i_value),
        .i_message_start (i_message_start),
        .o_push_valid    (push_valid),
        .i_push_ready    (push_ready),
        .o_push_cmd      (push_cmd)
    );

    rc4_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_cmd   (push_cmd),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_cmd    (pop_cmd)
    );

    rc4_core #(
        .KEY_MAX_BYTES (KEY_MAX_BYTES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_cmd       (pop_cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte)
    );

    a_key_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push_valid && (push_cmd.op == rc4_pkg::OP_KEY)
        |-> ({1'b0, push_cmd.idx} < 9'(KEY_MAX_BYTES)))
        else $error("out-of-range key write reached the queue");

    a_key_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop_valid && pop_ready && (pop_cmd.op == rc4_pkg::OP_KEY)
        |=> !$rose(o_out_valid))
        else $error("key request produced a result");

    a_result_frees_core: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> pop_ready)
        else $error("core not idle after loading a result");

endmodule

`default_nettype wire

// ===== sv/rc4_front.sv =====
// request intake: classifies requests and registers them toward the queue
`default_nettype none

module rc4_front #(
    parameter int KEY_MAX_BYTES = rc4_pkg::KEY_MAX_BYTES_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire logic          i_mode,
    input  wire logic [7:0]    i_key_index,
    input  wire logic [7:0]    i_value,
    input  wire logic          i_message_start,
    output logic               o_push_valid,
    input  wire logic          i_push_ready,
    output rc4_pkg::t_cmd      o_push_cmd
);

    localparam logic [8:0] KMAX = 9'(KEY_MAX_BYTES);

    logic          r_valid;
    rc4_pkg::t_cmd r_cmd;
    rc4_pkg::t_cmd n_cmd;
    logic          keep;

    always_comb begin
        n_cmd.idx   = i_key_index;
        n_cmd.value = i_value;
        keep        = 1'b1;
        if (i_mode) begin
            n_cmd.op = i_message_start ? rc4_pkg::OP_REKEY : rc4_pkg::OP_DATA;
        end else begin
            n_cmd.op = rc4_pkg::OP_KEY;
            // key writes beyond the store are dropped here
            keep     = ({1'b0, i_key_index} < KMAX);
        end
    end

    assign o_in_ready   = !r_valid || i_push_ready;
    assign o_push_valid = r_valid;
    assign o_push_cmd   = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_valid <= keep;
        end else if (i_push_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== sv/rc4_queue.sv =====
// two-entry command queue between intake and cipher core
`default_nettype none

module rc4_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push_valid,
    output logic               o_push_ready,
    input  wire rc4_pkg::t_cmd i_push_cmd,
    output logic               o_pop_valid,
    input  wire logic          i_pop_ready,
    output rc4_pkg::t_cmd      o_pop_cmd
);

    localparam int QD = rc4_pkg::Q_DEPTH;
    localparam int AW = rc4_pkg::Q_AW;
    localparam int CW = rc4_pkg::Q_CW;

    rc4_pkg::t_cmd r_q [QD];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic          push;
    logic          pop;

    assign o_push_ready = (r_cnt != CW'(QD));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_cmd    = r_q[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + AW'(1);
            end
            if (pop) begin
                r_rp <= r_rp + AW'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_push_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== sv/rc4_core.sv =====
// cipher core: key store, permutation memory, key schedule and keystream
`default_nettype none

module rc4_core #(
    parameter int KEY_MAX_BYTES = rc4_pkg::KEY_MAX_BYTES_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [rc4_pkg::LEN_W-1:0]  i_cfg_wdata,
    input  wire logic                       i_pop_valid,
    output logic                            o_pop_ready,
    input  wire rc4_pkg::t_cmd              i_cmd,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic [7:0]                      o_out_byte
);

    localparam int LW = rc4_pkg::LEN_W;
    localparam int KW = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1;
    localparam logic [LW-1:0] KMAX = LW'(KEY_MAX_BYTES);

    typedef enum logic [3:0] {
        S_IDLE,
        S_KS_INIT,
        S_KS_RD1,
        S_KS_RD2,
        S_KS_W1,
        S_KS_W2,
        S_G_RD1,
        S_G_RD2,
        S_G_W1,
        S_G_W2
    } t_state;

    t_state          r_state;
    logic [7:0]      r_i;
    logic [7:0]      r_j;
    logic [7:0]      r_n;
    logic [KW-1:0]   r_kpos;
    logic [7:0]      r_si;
    logic [7:0]      r_sj;
    logic [7:0]      r_value;
    logic [7:0]      r_ks_addr;
    logic            r_out_valid;
    logic [7:0]      r_out_byte;
    logic [LW-1:0]   r_kl;

    logic [7:0]      r_perm [256];
    logic [255:0]    r_pvld;
    logic [7:0]      r_prd_data;
    logic            r_prd_vld;
    logic [7:0]      r_prd_addr;
    logic [7:0]      r_key [KEY_MAX_BYTES];
    logic [7:0]      r_key_rd;

    logic [7:0]      perm_q;
    logic [7:0]      p_raddr;
    logic            p_we;
    logic [7:0]      p_waddr;
    logic [7:0]      p_wdata;
    logic            p_clr;
    logic            k_we;
    logic            pop;
    logic [7:0]      ks;
    logic            out_load;
    logic [LW-1:0]   len;
    logic [LW-1:0]   kpos_inc;

    // entries not yet written since the last clear read as identity
    assign perm_q = r_prd_vld ? r_prd_data : r_prd_addr;

    assign o_pop_ready = (r_state == S_IDLE);
    assign pop         = i_pop_valid && o_pop_ready;
    assign k_we        = pop && (i_cmd.op == rc4_pkg::OP_KEY);
    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;

    always_comb begin
        if (r_kl == '0) begin
            len = LW'(1);
        end else if (r_kl > KMAX) begin
            len = KMAX;
        end else begin
            len = r_kl;
        end
        kpos_inc = LW'(r_kpos) + LW'(1);
    end

    // swap writes to i and j not yet seen by the read port are forwarded, j first
    always_comb begin
        if (r_ks_addr == r_j) begin
            ks = r_si;
        end else if (r_ks_addr == r_i) begin
            ks = r_sj;
        end else begin
            ks = perm_q;
        end
        out_load = (r_state == S_G_W2) && (!r_out_valid || i_out_ready);
    end

    always_comb begin
        p_raddr = r_ks_addr;
        p_we    = 1'b0;
        p_waddr = r_n;
        p_wdata = perm_q;
        p_clr   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                p_raddr = r_i + 8'd1;
            end
            S_KS_INIT: begin
                p_clr = 1'b1;
            end
            S_KS_RD1: begin
                p_raddr = r_n;
            end
            S_KS_RD2: begin
                p_raddr = r_j + perm_q + r_key_rd;
            end
            S_KS_W1: begin
                p_we    = 1'b1;
                p_waddr = r_n;
                p_wdata = perm_q;
            end
            S_KS_W2: begin
                p_we    = 1'b1;
                p_waddr = r_j;
                p_wdata = r_si;
            end
            S_G_RD1: begin
                p_raddr = r_i + 8'd1;
            end
            S_G_RD2: begin
                p_raddr = r_j + perm_q;
            end
            S_G_W1: begin
                p_we    = 1'b1;
                p_waddr = r_i;
                p_wdata = perm_q;
                p_raddr = r_si + perm_q;
            end
            S_G_W2: begin
                p_we    = 1'b1;
                p_waddr = r_j;
                p_wdata = r_si;
            end
            default: begin
                p_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (p_we) begin
            r_perm[p_waddr] <= p_wdata;
        end
        r_prd_data <= r_perm[p_raddr];
        r_prd_addr <= p_raddr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || p_clr) begin
            r_pvld    <= '0;
            r_prd_vld <= 1'b0;
        end else begin
            if (p_we) begin
                r_pvld[p_waddr] <= 1'b1;
            end
            r_prd_vld <= r_pvld[p_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (k_we) begin
            r_key[i_cmd.idx[KW-1:0]] <= i_cmd.value;
        end
        r_key_rd <= r_key[r_kpos];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kl <= rc4_pkg::KEY_LENGTH_RST;
        end else if (i_cfg_we) begin
            r_kl <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_i         <= '0;
            r_j         <= '0;
            r_n         <= '0;
            r_kpos      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
                r_out_byte  <= r_value ^ ks;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (pop) begin
                        r_value <= i_cmd.value;
                        unique case (i_cmd.op)
                            rc4_pkg::OP_DATA: begin
                                r_i     <= r_i + 8'd1;
                                r_state <= S_G_RD2;
                            end
                            rc4_pkg::OP_REKEY: begin
                                r_state <= S_KS_INIT;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_KS_INIT: begin
                    r_i     <= '0;
                    r_j     <= '0;
                    r_n     <= '0;
                    r_kpos  <= '0;
                    r_state <= S_KS_RD1;
                end
                S_KS_RD1: begin
                    r_state <= S_KS_RD2;
                end
                S_KS_RD2: begin
                    r_si    <= perm_q;
                    r_j     <= p_raddr;
                    r_state <= S_KS_W1;
                end
                S_KS_W1: begin
                    r_state <= S_KS_W2;
                end
                S_KS_W2: begin
                    r_n <= r_n + 8'd1;
                    if (kpos_inc >= len) begin
                        r_kpos <= '0;
                    end else begin
                        r_kpos <= kpos_inc[KW-1:0];
                    end
                    if (r_n == 8'hFF) begin
                        r_j     <= '0;
                        r_state <= S_G_RD1;
                    end else begin
                        r_state <= S_KS_RD1;
                    end
                end
                S_G_RD1: begin
                    r_i     <= r_i + 8'd1;
                    r_state <= S_G_RD2;
                end
                S_G_RD2: begin
                    r_si    <= perm_q;
                    r_j     <= p_raddr;
                    r_state <= S_G_W1;
                end
                S_G_W1: begin
                    r_sj      <= perm_q;
                    r_ks_addr <= p_raddr;
                    r_state   <= S_G_W2;
                end
                S_G_W2: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
